[rtl/oaht_pkg.sv]
// Package for the open-addressed hash table.
// Holds operation, status and slot mark codes and the FNV-1a constants.
// No dependencies.
package oaht_pkg;

    localparam logic [1:0] OP_GET   = 2'd0;
    localparam logic [1:0] OP_SET   = 2'd1;
    localparam logic [1:0] OP_DEL   = 2'd2;
    localparam logic [1:0] OP_CLEAR = 2'd3;

    localparam logic [2:0] ST_INSERTED = 3'd0;
    localparam logic [2:0] ST_UPDATED  = 3'd1;
    localparam logic [2:0] ST_NOROOM   = 3'd2;
    localparam logic [2:0] ST_DELETED  = 3'd3;
    localparam logic [2:0] ST_NOTFOUND = 3'd4;
    localparam logic [2:0] ST_FOUND    = 3'd5;
    localparam logic [2:0] ST_CLEARED  = 3'd6;

    localparam logic [1:0] MARK_EMPTY = 2'd0;
    localparam logic [1:0] MARK_USED  = 2'd1;
    localparam logic [1:0] MARK_TOMB  = 2'd2;

    localparam logic [31:0] FNV_BASIS = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME = 32'd16777619;

    typedef logic [1:0] t_op;
    typedef logic [2:0] t_status;

endpackage

[rtl/oaht_if.sv]
// Channel interfaces of the open-addressed hash table: request and response.
// Depends on oaht_pkg for the payload types.
interface oaht_in_if;
    logic                 valid;
    logic                 ready;
    oaht_pkg::t_op        operation;
    logic [63:0]          key_bytes;
    logic [31:0]          new_value;

    modport source (output valid, operation, key_bytes, new_value, input ready);
    modport sink   (input valid, operation, key_bytes, new_value, output ready);
endinterface

interface oaht_out_if;
    logic                 valid;
    logic                 ready;
    oaht_pkg::t_status    status;
    logic [31:0]          read_value;
    logic [8:0]           entry_count;

    modport source (output valid, status, read_value, entry_count, input ready);
    modport sink   (input valid, status, read_value, entry_count, output ready);
endinterface

[rtl/open_address_hash_table.sv]
// Top level of the open-addressed key/value table with linear probing.
// Depends on oaht_pkg, oaht_if.sv (channels) and oaht_home (home slot unit).
//
// Channel  Dir  Payload                                  Transfer when
// i_req    in   operation, key_bytes, new_value          valid & ready
// o_rsp    out  status, read_value, entry_count          valid & ready
//
// Get, set and delete hash the key bytes at one a cycle, reduce the hash modulo
// TABLE_SLOTS, then probe slots at one slot a cycle through the slot memory,
// which has a registered read port beside a separate write port.
// Clear sweeps the slot memory, one slot a cycle.
// After reset the same sweep runs before i_req.ready rises.
// A finished result waits in the output register while the next request is taken.
module open_address_hash_table #(
    parameter int TABLE_SLOTS = 256,
    parameter int KEY_BYTES   = 8,
    parameter int VALUE_BITS  = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    oaht_in_if.sink     i_req,
    oaht_out_if.source  o_rsp
);
    import oaht_pkg::*;

    localparam int AW = $clog2(TABLE_SLOTS);
    localparam int CW = $clog2(TABLE_SLOTS + 1);
    localparam int KW = 8 * KEY_BYTES;
    localparam int VB = VALUE_BITS;
    localparam int EW = 2 + KW + VB;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_HASH  = 3'd1;
    localparam logic [2:0] S_PROBE = 3'd2;
    localparam logic [2:0] S_CLEAR = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [EW-1:0] r_mem [TABLE_SLOTS];
    logic [EW-1:0] r_rd_data;

    logic [2:0]    r_state;
    logic          r_boot;
    t_op           r_op;
    logic [KW-1:0] r_key;
    logic [VB-1:0] r_val;
    logic [CW-1:0] r_count;
    logic [AW-1:0] r_addr;
    logic [AW-1:0] r_daddr;
    logic          r_dvalid;
    logic [AW-1:0] r_n;
    logic          r_tomb_seen;
    logic [AW-1:0] r_tomb;
    t_status       r_res_status;
    logic [31:0]   r_res_rd;

    logic          r_ov;
    t_status       r_o_status;
    logic [31:0]   r_o_rd;
    logic [8:0]    r_o_cnt;

    logic          w_in_go;
    logic [KW-1:0] w_nkey;
    logic [63:0]   w_nv64;
    logic          w_hash_start;
    logic          w_home_done;
    logic [AW-1:0] w_home;

    logic [1:0]    w_mark;
    logic [KW-1:0] w_ekey;
    logic [VB-1:0] w_evalue;
    logic [63:0]   w_ev64;
    logic          w_last;
    logic          w_fin;
    logic          w_we;
    logic [AW-1:0] w_wa;
    logic [EW-1:0] w_wd;
    t_status       w_status;
    logic [31:0]   w_rd;
    logic          w_inc;
    logic          w_dec;
    logic          w_new_tomb;
    logic [31:0]   w_cnt32;

    assign w_in_go     = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE);
    assign w_nv64      = {32'b0, i_req.new_value};

    // Bytes from the first zero byte onwards are dropped from the key.
    always_comb begin
        logic live;
        live   = 1'b1;
        w_nkey = '0;
        for (int i = 0; i < KEY_BYTES; i++) begin
            if (i_req.key_bytes[8*i +: 8] == 8'd0) begin
                live = 1'b0;
            end
            if (live) begin
                w_nkey[8*i +: 8] = i_req.key_bytes[8*i +: 8];
            end
        end
    end

    assign w_hash_start = w_in_go && (
        (i_req.operation == OP_SET && r_count < CW'(TABLE_SLOTS)) ||
        ((i_req.operation == OP_GET || i_req.operation == OP_DEL) && r_count != '0));

    oaht_home #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .KEY_BYTES   (KEY_BYTES)
    ) u_home (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_hash_start),
        .i_key   (w_nkey),
        .o_done  (w_home_done),
        .o_home  (w_home)
    );

    assign w_mark   = r_rd_data[EW-1 -: 2];
    assign w_ekey   = r_rd_data[VB +: KW];
    assign w_evalue = r_rd_data[VB-1:0];
    assign w_ev64   = 64'(w_evalue);
    assign w_last   = (r_n == AW'(TABLE_SLOTS - 1));
    assign w_new_tomb = (w_mark == MARK_TOMB) && !r_tomb_seen;

    // Evaluation of the slot whose read data has just arrived.
    always_comb begin
        w_fin    = 1'b0;
        w_we     = 1'b0;
        w_wa     = r_daddr;
        w_wd     = {MARK_USED, r_key, r_val};
        w_status = ST_NOTFOUND;
        w_rd     = '0;
        w_inc    = 1'b0;
        w_dec    = 1'b0;
        if (r_state == S_CLEAR) begin
            w_we = 1'b1;
            w_wa = r_addr;
            w_wd = {MARK_EMPTY, {(KW+VB){1'b0}}};
        end else if (r_state == S_PROBE && r_dvalid) begin
            priority if (w_mark == MARK_EMPTY) begin
                w_fin = 1'b1;
                if (r_op == OP_SET) begin
                    w_we     = 1'b1;
                    w_wa     = r_tomb_seen ? r_tomb : r_daddr;
                    w_inc    = 1'b1;
                    w_status = ST_INSERTED;
                end
            end else if (w_mark == MARK_USED && w_ekey == r_key) begin
                w_fin = 1'b1;
                priority if (r_op == OP_GET) begin
                    w_status = ST_FOUND;
                    w_rd     = w_ev64[31:0];
                end else if (r_op == OP_DEL) begin
                    w_we     = 1'b1;
                    w_wd     = {MARK_TOMB, {(KW+VB){1'b0}}};
                    w_dec    = 1'b1;
                    w_status = ST_DELETED;
                end else begin
                    w_we     = 1'b1;
                    w_status = ST_UPDATED;
                end
            end else if (w_last) begin
                // Every slot visited: set may still reuse a tombstone.
                w_fin = 1'b1;
                if (r_op == OP_SET) begin
                    if (r_tomb_seen || w_new_tomb) begin
                        w_we     = 1'b1;
                        w_wa     = r_tomb_seen ? r_tomb : r_daddr;
                        w_inc    = 1'b1;
                        w_status = ST_INSERTED;
                    end else begin
                        w_status = ST_NOROOM;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        r_rd_data <= r_mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_boot      <= 1'b1;
            r_addr      <= '0;
            r_count     <= '0;
            r_dvalid    <= 1'b0;
            r_tomb_seen <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_go) begin
                        r_op  <= i_req.operation;
                        r_key <= w_nkey;
                        r_val <= w_nv64[VB-1:0];
                        r_res_rd <= '0;
                        if (w_hash_start) begin
                            r_state <= S_HASH;
                        end else if (i_req.operation == OP_CLEAR) begin
                            r_state <= S_CLEAR;
                            r_addr  <= '0;
                        end else begin
                            r_state      <= S_DONE;
                            r_res_status <= (i_req.operation == OP_SET) ?
                                            ST_NOROOM : ST_NOTFOUND;
                        end
                    end
                end
                S_HASH: begin
                    if (w_home_done) begin
                        r_state     <= S_PROBE;
                        r_addr      <= w_home;
                        r_n         <= '0;
                        r_dvalid    <= 1'b0;
                        r_tomb_seen <= 1'b0;
                    end
                end
                S_PROBE: begin
                    // Reads run one slot ahead of the evaluation.
                    r_addr   <= (r_addr == AW'(TABLE_SLOTS - 1)) ? '0 : r_addr + 1'b1;
                    r_daddr  <= r_addr;
                    r_dvalid <= 1'b1;
                    if (r_dvalid) begin
                        r_n <= r_n + 1'b1;
                        if (w_new_tomb) begin
                            r_tomb_seen <= 1'b1;
                            r_tomb      <= r_daddr;
                        end
                    end
                    if (w_fin) begin
                        r_state      <= S_DONE;
                        r_dvalid     <= 1'b0;
                        r_res_status <= w_status;
                        r_res_rd     <= w_rd;
                        if (w_inc) begin
                            r_count <= r_count + 1'b1;
                        end else if (w_dec) begin
                            r_count <= r_count - 1'b1;
                        end
                    end
                end
                S_CLEAR: begin
                    r_addr <= (r_addr == AW'(TABLE_SLOTS - 1)) ? '0 : r_addr + 1'b1;
                    if (r_addr == AW'(TABLE_SLOTS - 1)) begin
                        r_count <= '0;
                        r_boot  <= 1'b0;
                        if (r_boot) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_state      <= S_DONE;
                            r_res_status <= ST_CLEARED;
                            r_res_rd     <= '0;
                        end
                    end
                end
                S_DONE: begin
                    if (!r_ov || o_rsp.ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign w_cnt32 = 32'(r_count);

    // Output register: loaded from the finished operation, freed by a transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (r_state == S_DONE && (!r_ov || o_rsp.ready)) begin
            r_ov       <= 1'b1;
            r_o_status <= r_res_status;
            r_o_rd     <= r_res_rd;
            r_o_cnt    <= w_cnt32[8:0];
        end else if (r_ov && o_rsp.ready) begin
            r_ov <= 1'b0;
        end
    end

    assign o_rsp.valid       = r_ov;
    assign o_rsp.status      = r_o_status;
    assign o_rsp.read_value  = r_o_rd;
    assign o_rsp.entry_count = r_o_cnt;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_SLOTS))
        else $error("occupied count exceeds table size");

    a_probe_write_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PROBE && w_we) |-> w_fin)
        else $error("slot written before the probe finished");

    a_delete_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fin && w_dec) |=> r_count == $past(r_count) - 1'b1)
        else $error("delete did not lower the count");

    a_home_in_hash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_home_done |-> r_state == S_HASH)
        else $error("home slot arrived outside the hash wait");
`endif

endmodule

[rtl/oaht_home.sv]
// Home slot unit: FNV-1a hash over the key bytes, one byte a cycle, then the
// remainder modulo TABLE_SLOTS, eight hash bits a cycle. Depends on oaht_pkg.
module oaht_home #(
    parameter int TABLE_SLOTS = 256,
    parameter int KEY_BYTES   = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [8*KEY_BYTES-1:0]           i_key,
    output logic                             o_done,
    output logic [$clog2(TABLE_SLOTS)-1:0]   o_home
);
    import oaht_pkg::*;

    localparam int AW = $clog2(TABLE_SLOTS);
    localparam int KW = 8 * KEY_BYTES;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_HASH = 2'd1;
    localparam logic [1:0] PH_MOD  = 2'd2;

    logic [1:0]    r_phase;
    logic [3:0]    r_cnt;
    logic [KW-1:0] r_key;
    logic [31:0]   r_h;
    logic [AW-1:0] r_rem;
    logic          r_done;
    logic [AW-1:0] r_home;

    logic [7:0]    w_b;
    logic [31:0]   w_prod;
    logic [AW-1:0] w_rem_next;

    assign w_b    = r_key[7:0];
    assign w_prod = 32'((r_h ^ {24'b0, w_b}) * FNV_PRIME);

    // Restoring remainder: shift in one hash bit, subtract the table size once.
    always_comb begin
        logic [AW:0]   t;
        logic [AW-1:0] t_rem;
        t_rem = r_rem;
        for (int i = 7; i >= 0; i--) begin
            t = {t_rem, r_h[24+i]};
            if (t >= (AW+1)'(TABLE_SLOTS)) begin
                t = t - (AW+1)'(TABLE_SLOTS);
            end
            t_rem = t[AW-1:0];
        end
        w_rem_next = t_rem;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_phase)
                PH_IDLE: begin
                    if (i_start) begin
                        r_phase <= PH_HASH;
                        r_key   <= i_key;
                        r_cnt   <= '0;
                        r_h     <= FNV_BASIS;
                    end
                end
                PH_HASH: begin
                    if (w_b == 8'd0 || r_cnt == 4'(KEY_BYTES)) begin
                        r_phase <= PH_MOD;
                        r_cnt   <= '0;
                        r_rem   <= '0;
                    end else begin
                        r_h   <= w_prod;
                        r_key <= r_key >> 8;
                        r_cnt <= r_cnt + 4'd1;
                    end
                end
                PH_MOD: begin
                    r_rem <= w_rem_next;
                    r_h   <= r_h << 8;
                    r_cnt <= r_cnt + 4'd1;
                    if (r_cnt == 4'd3) begin
                        r_phase <= PH_IDLE;
                        r_home  <= w_rem_next;
                        r_done  <= 1'b1;
                    end
                end
                default: r_phase <= PH_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_home = r_home;

endmodule

[verif/oaht_checker.sv]
// Checker for the open-addressed hash table: watches both channels, predicts results.
// Depends on oaht_pkg and the channel interfaces in oaht_if.sv.
module oaht_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    oaht_in_if.sink    i_req,
    oaht_out_if.sink   i_rsp,
    output int         o_fail_count,
    output int         o_pending,
    output int         o_results
);
    import oaht_pkg::*;

    typedef struct packed {
        t_status     status;
        logic [31:0] read_value;
        logic [8:0]  entry_count;
    } t_result;

    logic [1:0]  tbl_mark  [256];
    logic [63:0] tbl_key   [256];
    logic [31:0] tbl_value [256];
    int          tbl_count;
    t_result     expected_results[$];

    // Key normalisation and FNV-1a home slot.
    function automatic void hash_key(input logic [63:0] raw, output logic [63:0] key,
                                     output logic [7:0] home);
        logic [31:0] h;
        logic [7:0]  b;
        h   = FNV_BASIS;
        key = '0;
        for (int i = 0; i < 8; i++) begin
            b = raw[8*i +: 8];
            if (b == 8'd0) break;
            key[8*i +: 8] = b;
            h = (h ^ {24'd0, b}) * FNV_PRIME;
        end
        home = h[7:0];
    endfunction

    function automatic t_result predict_table(input t_op op, input logic [63:0] raw,
                                              input logic [31:0] val);
        t_result     r;
        logic [63:0] key;
        logic [7:0]  home, h;
        int          tomb, pos;
        bit          finished;
        hash_key(raw, key, home);
        r.status = ST_NOTFOUND;
        r.read_value = '0;
        if (op == OP_CLEAR) begin
            for (int i = 0; i < 256; i++) tbl_mark[i] = MARK_EMPTY;
            tbl_count = 0;
            r.status = ST_CLEARED;
        end else if (op == OP_SET) begin
            if (tbl_count >= 256) begin
                r.status = ST_NOROOM;
            end else begin
                h = home; tomb = -1; pos = -1; finished = 0;
                for (int n = 0; n < 256; n++) begin
                    if (tbl_mark[h] == MARK_EMPTY) begin
                        pos = h;
                        break;
                    end
                    if (tbl_mark[h] == MARK_USED && tbl_key[h] == key) begin
                        tbl_value[h] = val;
                        r.status = ST_UPDATED;
                        finished = 1;
                        break;
                    end
                    if (tbl_mark[h] == MARK_TOMB && tomb < 0) tomb = h;
                    h = h + 8'd1;
                end
                if (!finished) begin
                    if (tomb >= 0) pos = tomb;
                    if (pos < 0) begin
                        r.status = ST_NOROOM;
                    end else begin
                        tbl_mark[pos] = MARK_USED;
                        tbl_key[pos] = key;
                        tbl_value[pos] = val;
                        tbl_count++;
                        r.status = ST_INSERTED;
                    end
                end
            end
        end else if (tbl_count != 0) begin
            h = home;
            for (int n = 0; n < 256; n++) begin
                if (tbl_mark[h] == MARK_EMPTY) break;
                if (tbl_mark[h] == MARK_USED && tbl_key[h] == key) begin
                    if (op == OP_GET) begin
                        r.read_value = tbl_value[h];
                        r.status = ST_FOUND;
                    end else begin
                        tbl_mark[h] = MARK_TOMB;
                        tbl_count--;
                        r.status = ST_DELETED;
                    end
                    break;
                end
                h = h + 8'd1;
            end
        end
        r.entry_count = tbl_count[8:0];
        return r;
    endfunction

    initial begin
        for (int i = 0; i < 256; i++) tbl_mark[i] = MARK_EMPTY;
        tbl_count = 0;
        o_fail_count = 0;
        o_results = 0;
    end

    assign o_pending = expected_results.size();

    always @(posedge i_clk) begin
        t_result got, want;
        if (i_rst_n && i_req.valid && i_req.ready)
            expected_results.push_back(predict_table(i_req.operation, i_req.key_bytes,
                                                     i_req.new_value));
        if (i_rst_n && i_rsp.valid && i_rsp.ready) begin
            got = '{i_rsp.status, i_rsp.read_value, i_rsp.entry_count};
            o_results <= o_results + 1;
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result %p", $time, got);
                o_fail_count <= o_fail_count + 1;
            end else begin
                want = expected_results.pop_front();
                if (got != want) begin
                    $display("%0t: mismatch expected %p actual %p", $time, want, got);
                    o_fail_count <= o_fail_count + 1;
                end
            end
        end
    end
endmodule

[verif/tb.sv]
// Testbench top for the open-addressed hash table: clock, reset, stimulus, verdict.
// Depends on oaht_pkg, oaht_if.sv, the block and oaht_checker.
module tb;
    import oaht_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   fail_count, pending, results;
    bit   no_idle = 0;
    bit   long_hold = 0;
    bit   stim_done = 0;
    logic [63:0] key_pool [16];

    oaht_in_if  req_ch ();
    oaht_out_if rsp_ch ();

    open_address_hash_table u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(req_ch.sink), .o_rsp(rsp_ch.source)
    );

    oaht_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(req_ch.sink), .i_rsp(rsp_ch.sink),
        .o_fail_count(fail_count), .o_pending(pending), .o_results(results)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        req_ch.valid = 1'b0;
        req_ch.operation = OP_GET;
        req_ch.key_bytes = '0;
        req_ch.new_value = '0;
        rsp_ch.ready = 1'b0;
    end

    // Receiver: random stalls, or a long hold-off counted in cycles.
    always @(negedge i_clk) begin
        if (long_hold) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            rsp_ch.ready <= no_idle || ($urandom_range(99) >= 32);
        end
    end

    initial begin
        repeat (300) @(negedge i_clk);
        long_hold = 1;
        repeat (600) @(negedge i_clk);
        long_hold = 0;
    end

    // Valid stays high between back-to-back requests; it drops only while idling and in wait_drained.
    task automatic send_request(input t_op op, input logic [63:0] key, input logic [31:0] val);
        while (!no_idle && $urandom_range(99) < 32) begin
            req_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.operation <= op;
        req_ch.key_bytes <= key;
        req_ch.new_value <= val;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic logic [63:0] random_key();
        logic [63:0] k;
        k = {$urandom, $urandom};
        case ($urandom_range(3))
            0: k = key_pool[$urandom_range(15)];
            1: k[8*$urandom_range(7) +: 8] = 8'd0;
            default: ;
        endcase
        return k;
    endfunction

    // Distinct keys without zero bytes, so that every one is a full eight-byte key.
    function automatic logic [63:0] fill_key(input int idx);
        return {32'hA5C3_5A5A, 8'h11, 8'(1 + idx % 250), 8'(1 + idx / 250), 8'h33};
    endfunction

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    initial begin
        t_op op;
        for (int i = 0; i < 16; i++)
            key_pool[i] = {$urandom, $urandom} | 64'h0101_0101_0101_0101;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty table, extreme keys and values, tombstones, clear.
        send_request(OP_GET, 64'h61, 32'd0);
        send_request(OP_DEL, 64'h61, 32'd0);
        send_request(OP_SET, 64'h0, 32'hFFFF_FFFF);
        send_request(OP_GET, 64'hFF00_0000_0000_0000, 32'd0);
        send_request(OP_SET, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0);
        send_request(OP_SET, 64'hFFFF_FFFF_FFFF_FFFF, 32'h8000_0001);
        send_request(OP_GET, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0);
        send_request(OP_SET, 64'h0000_0000_0000_0062, 32'h1234_5678);
        send_request(OP_GET, 64'h5555_0000_0000_0062, 32'd0);
        send_request(OP_DEL, 64'h0000_0000_0000_0062, 32'd0);
        send_request(OP_GET, 64'h62, 32'd0);
        send_request(OP_SET, 64'h0101_0101_0101_0101, 32'h5A5A_A5A5);
        send_request(OP_DEL, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0);
        send_request(OP_CLEAR, 64'h0, 32'd0);
        send_request(OP_GET, 64'h0101_0101_0101_0101, 32'd0);

        // Fill the table completely, then probe the full and wrapped cases.
        no_idle = 1;
        for (int i = 0; i < 258; i++)
            send_request(OP_SET, fill_key(i), $urandom);
        send_request(OP_GET, 64'h77, 32'd0);
        send_request(OP_DEL, fill_key(5), 32'd0);
        send_request(OP_SET, 64'h77, 32'd9);
        send_request(OP_SET, 64'h78, 32'd9);
        no_idle = 0;
        send_request(OP_CLEAR, 64'h0, 32'd0);

        // Pause until everything has come back.
        wait_drained();

        for (int i = 0; i < 120; i++) begin
            if (i >= 40 && i < 80) no_idle = 1; else no_idle = 0;
            case ($urandom_range(99)) inside
                [0:44]:  op = OP_SET;
                [45:74]: op = OP_GET;
                [75:97]: op = OP_DEL;
                default: op = OP_CLEAR;
            endcase
            send_request(op, random_key(), $urandom);
        end
        stim_done = 1;
        no_idle = 1;
        wait_drained();
        $display("Covered directed edge cases, a full table with wrapped probes and");
        $display("120 random requests; %0d results checked.", results);
        if (fail_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("end of test: mismatches");
        $finish;
    end
endmodule

[sim.f]
rtl/oaht_pkg.sv
rtl/oaht_if.sv
rtl/oaht_home.sv
rtl/open_address_hash_table.sv
verif/oaht_checker.sv
verif/tb.sv
